FILE: src/rgb_to_hsv_converter_assert.svh
// Assertion macros for the RGB to HSV converter.
// Expects the including module to have the ports aclk and aresetn.
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// General form: explicit clock and active-low reset.
`define RHC_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Short form on the block's own clock and reset.
`define RHC_ASSERT(label, prop, msg) \
    `RHC_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

FILE: src/rhc_pkg.sv
// Package for the RGB to HSV converter: widths, pipeline sizing and types.
// Used by rgb_to_hsv_converter; depends on nothing.
`default_nettype none
package rhc_pkg;

    localparam int HUE_BITS        = 16;
    localparam int CH_W            = 8;
    localparam int HUE_OUT_W       = 16;
    localparam int HDIV_W          = 11;  // holds 6 * 255
    localparam int SAT_BITS        = 8;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = (HUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // First stage: extremes and the sector of the hue.
    typedef struct packed {
        logic [CH_W-1:0]        value;
        logic [CH_W-1:0]        delta;
        sector_t                sector;
        logic signed [CH_W:0]   diff;
    } pre_t;

    // Divider stages: partial remainders and quotients of both divisions.
    typedef struct packed {
        logic [HDIV_W-1:0]   hrem;
        logic [HDIV_W-1:0]   hdiv;
        logic [HUE_BITS-1:0] hq;
        logic [CH_W-1:0]     srem;
        logic [CH_W-1:0]     sdiv;
        logic [CH_W-1:0]     slow;
        logic [SAT_BITS-1:0] sq;
        logic [CH_W-1:0]     value;
    } div_t;

endpackage
`default_nettype wire

FILE: src/rgb_to_hsv_converter.sv
// RGB to HSV converter, pipelined with two restoring-division steps per divider stage; one
// pixel per cycle sustained while the output is not stalled (m_ready held high).
// Reset (aresetn, synchronous, active low) empties the pipeline; payloads are not reset.
// Depends on rhc_pkg and rgb_to_hsv_converter_assert.svh.
`default_nettype none
`include "rgb_to_hsv_converter_assert.svh"
module rgb_to_hsv_converter (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [rhc_pkg::CH_W-1:0]     s_red_in,
    input  wire logic [rhc_pkg::CH_W-1:0]     s_green_in,
    input  wire logic [rhc_pkg::CH_W-1:0]     s_blue_in,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [rhc_pkg::HUE_OUT_W-1:0]     m_hue_out,
    output logic [rhc_pkg::CH_W-1:0]          m_saturation_out,
    output logic [rhc_pkg::CH_W-1:0]          m_value_out
);
    import rhc_pkg::*;

    // The pipeline is a chain of registered stages, each with its own valid bit.
    // Stage one finds the largest and smallest channel and the hue sector.
    // Stage two forms the hue numerator and divisor and the saturation dividend.
    // Then DIV_STAGES divider stages each retire two quotient bits of the hue
    // division, and, over the first stages, two bits of the saturation division.
    // A stage takes a new beat whenever it is empty or its successor takes its
    // beat, so bubbles close up and a stalled output holds everything behind it.

    pre_t             pre_reg,  pre_next;
    logic             pre_valid_reg;
    div_t             dv_reg    [0:DIV_STAGES];
    div_t             dv_next   [0:DIV_STAGES];
    logic             dv_valid_reg [0:DIV_STAGES];
    logic             dv_ready  [0:DIV_STAGES];
    logic             pre_ready;

    // Ready chain, from the output back to the input.
    assign dv_ready[DIV_STAGES] = !dv_valid_reg[DIV_STAGES] || m_ready;
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_ready
        assign dv_ready[k] = !dv_valid_reg[k] || dv_ready[k+1];
    end
    assign pre_ready = !pre_valid_reg || dv_ready[0];
    assign s_ready   = pre_ready;

    // Stage one: maximum, minimum, sector and signed channel difference.
    // Ties for the maximum go to red, then to green.
    always_comb begin
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        mx = s_red_in;
        if (s_green_in > mx) mx = s_green_in;
        if (s_blue_in > mx)  mx = s_blue_in;
        mn = s_red_in;
        if (s_green_in < mn) mn = s_green_in;
        if (s_blue_in < mn)  mn = s_blue_in;
        pre_next.value = mx;
        pre_next.delta = mx - mn;
        priority if (mx == s_red_in) begin
            pre_next.sector = SECT_RED;
            pre_next.diff   = $signed({1'b0, s_green_in}) - $signed({1'b0, s_blue_in});
        end else if (mx == s_green_in) begin
            pre_next.sector = SECT_GREEN;
            pre_next.diff   = $signed({1'b0, s_blue_in}) - $signed({1'b0, s_red_in});
        end else begin
            pre_next.sector = SECT_BLUE;
            pre_next.diff   = $signed({1'b0, s_red_in}) - $signed({1'b0, s_green_in});
        end
    end

    // Stage two: the hue numerator is base * delta + diff, wrapped into
    // [0, 6 * delta); only the red sector can go negative. A grey or black
    // pixel gets hue divisor one and zero dividends, so its quotients come out 0.
    always_comb begin
        logic [HDIV_W-1:0] six_delta;
        logic [HDIV_W-2:0] base;
        logic [HDIV_W:0]   sum;
        logic [2*CH_W-1:0] sdvd;
        six_delta = {1'b0, pre_reg.delta, 2'b00} + {2'b00, pre_reg.delta, 1'b0};
        unique case (pre_reg.sector)
            SECT_RED:   base = '0;
            SECT_GREEN: base = {1'b0, pre_reg.delta, 1'b0};
            SECT_BLUE:  base = {pre_reg.delta, 2'b00};
            default:    base = '0;
        endcase
        sum = {2'b00, base} + {{(HDIV_W-CH_W){pre_reg.diff[CH_W]}}, pre_reg.diff};
        if (sum[HDIV_W]) begin
            sum = sum + {1'b0, six_delta};
        end
        sdvd = {pre_reg.delta, {CH_W{1'b0}}} - {{CH_W{1'b0}}, pre_reg.delta};
        dv_next[0].hrem  = sum[HDIV_W-1:0];
        dv_next[0].hdiv  = (pre_reg.delta == '0) ? HDIV_W'(1) : six_delta;
        dv_next[0].hq    = '0;
        // 255 * delta / 256 is below delta, so the top byte is a valid first remainder.
        dv_next[0].srem  = sdvd[2*CH_W-1:CH_W];
        dv_next[0].slow  = sdvd[CH_W-1:0];
        dv_next[0].sdiv  = (pre_reg.value == '0) ? CH_W'(1) : pre_reg.value;
        dv_next[0].sq    = '0;
        dv_next[0].value = pre_reg.value;
    end

    // Divider stages: restoring division, two steps each.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        always_comb begin
            div_t            d;
            logic [HDIV_W:0] ht;
            logic [CH_W:0]   st;
            d = dv_reg[k];
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                if (k * STEPS_PER_STAGE + j < HUE_BITS) begin
                    ht = {d.hrem, 1'b0};
                    if (ht >= {1'b0, d.hdiv}) begin
                        ht   = ht - {1'b0, d.hdiv};
                        d.hq = {d.hq[HUE_BITS-2:0], 1'b1};
                    end else begin
                        d.hq = {d.hq[HUE_BITS-2:0], 1'b0};
                    end
                    d.hrem = ht[HDIV_W-1:0];
                end
                if (k * STEPS_PER_STAGE + j < SAT_BITS) begin
                    st     = {d.srem, d.slow[CH_W-1]};
                    d.slow = {d.slow[CH_W-2:0], 1'b0};
                    if (st >= {1'b0, d.sdiv}) begin
                        st   = st - {1'b0, d.sdiv};
                        d.sq = {d.sq[SAT_BITS-2:0], 1'b1};
                    end else begin
                        d.sq = {d.sq[SAT_BITS-2:0], 1'b0};
                    end
                    d.srem = st[CH_W-1:0];
                end
            end
            dv_next[k+1] = d;
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                dv_valid_reg[k] <= 1'b0;
            end
        end else begin
            if (pre_ready) pre_valid_reg <= s_valid;
            if (dv_ready[0]) dv_valid_reg[0] <= pre_valid_reg;
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (dv_ready[k+1]) dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end
    end

    // Payload registers load only when a beat moves in.
    always_ff @(posedge aclk) begin
        if (pre_ready && s_valid) pre_reg <= pre_next;
        if (dv_ready[0] && pre_valid_reg) dv_reg[0] <= dv_next[0];
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (dv_ready[k+1] && dv_valid_reg[k]) dv_reg[k+1] <= dv_next[k+1];
        end
    end

    // Output stage; a hue wider than the port keeps its low bits.
    assign m_valid          = dv_valid_reg[DIV_STAGES];
    assign m_hue_out        = HUE_OUT_W'(dv_reg[DIV_STAGES].hq);
    assign m_saturation_out = dv_reg[DIV_STAGES].sq;
    assign m_value_out      = dv_reg[DIV_STAGES].value;

    // A free output slot lets every stage move, so the input must be open.
    `RHC_ASSERT(a_ready_chain, m_ready |-> s_ready, "input stalled while output is free")
    // A black pixel has neither saturation nor hue.
    `RHC_ASSERT(a_black, (m_valid && m_value_out == '0) |-> (m_saturation_out == '0 && m_hue_out == '0), "black pixel with colour")
    // Zero saturation means a grey pixel, whose hue is zero.
    `RHC_ASSERT(a_grey, (m_valid && m_saturation_out == '0) |-> (m_hue_out == '0), "grey pixel with hue")

endmodule
`default_nettype wire
